FILE: src/bbg_pkg.sv
// ----------------------------------------------------------------------------
// bbg_pkg - shared definitions for the breathing brightness generator
// Constants, register indexes and the divider request/response structs.
// ----------------------------------------------------------------------------
package bbg_pkg;

	// Default fixed-point setup
	localparam int FRACTION_BITS    = 10;
	localparam int SINE_TABLE_DEPTH = 256;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 8'd3;

	// Divider geometry: 17-bit dividend, 16-bit divisor
	localparam int DIV_W  = 16;
	localparam int NUM_W  = DIV_W + 1;
	localparam int STEP_W = 5;

	// Fixed-point constants for the sine table build
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [16:0] SINE_FULL   = 17'd32768;

	// Divider request: start pulse, iteration count and operands
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  rem_init;
		logic [NUM_W-1:0]  num;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	// Divider response: done pulse, remainder and quotient bits
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] rem;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: src/bbg_divider.sv
// ----------------------------------------------------------------------------
// bbg_divider - restoring divider, one quotient bit per cycle
// Starts from a partial remainder below the divisor and shifts in the
// dividend MSB first; the quotient bits replace the dividend bits.
// ----------------------------------------------------------------------------
module bbg_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  bbg_pkg::div_req_t req,
	output bbg_pkg::div_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [bbg_pkg::STEP_W-1:0] cnt_q;
	logic [bbg_pkg::DIV_W-1:0]  rem_q;
	logic [bbg_pkg::NUM_W-1:0]  num_q;

	logic [bbg_pkg::DIV_W:0]    trial;
	logic [bbg_pkg::DIV_W:0]    trial_sub;
	logic                       fits;
	logic [bbg_pkg::DIV_W-1:0]  rem_nxt;

	// One trial subtraction per cycle
	always_comb begin
		trial     = {rem_q, num_q[bbg_pkg::NUM_W-1]};
		trial_sub = trial - {1'b0, req.divisor};
		fits      = (trial >= {1'b0, req.divisor});
		rem_nxt   = fits ? trial_sub[bbg_pkg::DIV_W-1:0] : trial[bbg_pkg::DIV_W-1:0];
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bbg_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and dividend/quotient shifter
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			num_q <= req.num;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			num_q <= {num_q[bbg_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = num_q;

endmodule

FILE: src/breathing_brightness_generator.sv
// ----------------------------------------------------------------------------
// breathing_brightness_generator - sine / triangle breathing brightness
// Per running tick: phase = (phase + delta) mod period, progress = phase/period
// (both cleared for a zero period); waveform by mode, then brightness = min + t*(max-min).
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     tdata: delta_time, tuser: running
// m_*       out  m_tvalid / m_tready     tdata: brightness
// cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A running tick with a nonzero period passes through the shared divider
// twice, first for the modulo and then for the progress fraction, before the
// waveform lookup and level mapping states S_ANGLE, S_QUAD, S_TABLE, S_LEVEL,
// S_MUL and S_OUT. Other ticks go straight to those states.
// s_tready is high only while the sequencer is idle; the result sits in an
// output register, so a stalled m_tready delays only the final step.
// The asynchronous reset clears phase, progress, the period and both levels,
// and selects sine mode; no clearing pass is needed since the sine table is constant.
//
module breathing_brightness_generator #(
	parameter int FractionBits   = bbg_pkg::FRACTION_BITS,
	parameter int SineTableDepth = bbg_pkg::SINE_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input ticks
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] delta_time
	input  logic                          s_tuser,   // [0] running
	// brightness results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] brightness
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int AngleW = $clog2(4 * SineTableDepth);
	localparam int IdxW   = $clog2(SineTableDepth);
	localparam int ProdW  = FractionBits + AngleW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_FRAC,
		S_ANGLE,
		S_QUAD,
		S_TABLE,
		S_LEVEL,
		S_MUL,
		S_OUT
	} state_t;

	// Quarter-wave sine entry, Q30 Taylor series then rounded to Q1.15
	function automatic logic [15:0] quarter_sine(input int unsigned idx);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] tv;
		logic [63:0] s;
		x  = (64'(idx) * bbg_pkg::HALF_PI_Q30) / 64'(SineTableDepth);
		x2 = (x * x) >> 30;
		tv = bbg_pkg::Q30_ONE;
		// Horner terms, divisors 13*12 down to 3*2
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd156);
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd110);
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd72);
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd42);
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd20);
		tv = bbg_pkg::Q30_ONE - (((x2 * tv) >> 30) / 64'd6);
		s  = (x * tv) >> 30;
		s  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
		if (s > 64'd65535) begin
			s = 64'd65535;
		end
		return s[15:0];
	endfunction

	// Constant sine table
	logic [15:0] sine_rom [SineTableDepth];
	for (genvar gi = 0; gi < SineTableDepth; gi++) begin : g_rom
		assign sine_rom[gi] = quarter_sine(gi);
	end

	// Registers
	state_t                    state_q;
	logic [15:0]               period_q;
	logic [7:0]                min_q;
	logic [7:0]                max_q;
	logic                      smooth_q;
	logic [15:0]               phase_q;
	logic [FractionBits-1:0]   prog_q;
	logic                      div_start_q;
	logic [bbg_pkg::NUM_W-1:0] sum_q;
	logic [AngleW-1:0]         angle_q;
	logic [1:0]                quad_q;
	logic                      rzero_q;
	logic [IdxW-1:0]           idx_q;
	logic [15:0]               tbl_q;
	logic [16:0]               t_q;
	logic signed [26:0]        prod_q;
	logic                      m_tvalid_q;
	logic [7:0]                m_tdata_q;

	bbg_pkg::div_req_t div_req;
	bbg_pkg::div_rsp_t div_rsp;

	logic                in_fire;
	logic                out_free;
	logic [ProdW-1:0]    angle_prod;
	logic [1:0]          quad_c;
	logic [AngleW-1:0]   r_full;
	logic [AngleW-1:0]   r_mirror;
	logic [FractionBits-1:0] lin_mag;
	logic [16:0]         lin_t;
	logic [16:0]         sin_mag;
	logic [16:0]         sin_t;
	logic signed [17:0]  t_s;
	logic signed [8:0]   level_diff;
	logic signed [26:0]  level_sum;

	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Divider request: modulo pass, then fraction pass
	always_comb begin
		div_req.start    = div_start_q;
		div_req.divisor  = period_q;
		div_req.num      = (state_q == S_MOD) ? sum_q : '0;
		div_req.rem_init = (state_q == S_MOD) ? '0 : phase_q;
		div_req.steps    = (state_q == S_MOD) ? bbg_pkg::STEP_W'(bbg_pkg::NUM_W)
		                                      : bbg_pkg::STEP_W'(FractionBits);
	end

	bbg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Angle index and quadrant split
	always_comb begin
		angle_prod = ProdW'(prog_q) * ProdW'(4 * SineTableDepth);
		if (angle_q >= AngleW'(3 * SineTableDepth)) begin
			quad_c = 2'd3;
			r_full = angle_q - AngleW'(3 * SineTableDepth);
		end else if (angle_q >= AngleW'(2 * SineTableDepth)) begin
			quad_c = 2'd2;
			r_full = angle_q - AngleW'(2 * SineTableDepth);
		end else if (angle_q >= AngleW'(SineTableDepth)) begin
			quad_c = 2'd1;
			r_full = angle_q - AngleW'(SineTableDepth);
		end else begin
			quad_c = 2'd0;
			r_full = angle_q;
		end
		r_mirror = AngleW'(SineTableDepth) - r_full;
	end

	// Waveform to unsigned t in [0, 1.0] with 16 fraction bits
	always_comb begin
		if (!prog_q[FractionBits-1]) begin
			lin_mag = prog_q;
		end else begin
			lin_mag = FractionBits'((FractionBits+1)'(1 << FractionBits)
			          - (FractionBits+1)'(prog_q));
		end
		lin_t   = bbg_pkg::SINE_FULL + (17'(lin_mag) << (16 - FractionBits));
		sin_mag = (quad_q[0] && rzero_q) ? bbg_pkg::SINE_FULL : 17'(tbl_q);
		sin_t   = quad_q[1] ? (bbg_pkg::SINE_FULL - sin_mag) : (bbg_pkg::SINE_FULL + sin_mag);
	end

	// Level mapping
	always_comb begin
		t_s        = $signed({1'b0, t_q});
		level_diff = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		level_sum  = $signed({3'b000, min_q, 16'h0000}) + prod_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
			smooth_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bbg_pkg::REG_PERIOD: period_q <= cfg_data;
				bbg_pkg::REG_MIN:    min_q    <= cfg_data[7:0];
				bbg_pkg::REG_MAX:    max_q    <= cfg_data[7:0];
				bbg_pkg::REG_SMOOTH: smooth_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer with phase, progress and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			prog_q      <= '0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (s_tuser && (period_q != '0)) begin
							div_start_q <= 1'b1;
							state_q     <= S_MOD;
						end else begin
							if (s_tuser) begin
								phase_q <= '0;
								prog_q  <= '0;
							end
							state_q <= S_ANGLE;
						end
					end
				end
				S_MOD: begin
					if (div_rsp.done) begin
						phase_q     <= div_rsp.rem;
						div_start_q <= 1'b1;
						state_q     <= S_FRAC;
					end
				end
				S_FRAC: begin
					if (div_rsp.done) begin
						prog_q  <= div_rsp.quo[FractionBits-1:0];
						state_q <= S_ANGLE;
					end
				end
				S_ANGLE: state_q <= S_QUAD;
				S_QUAD:  state_q <= S_TABLE;
				S_TABLE: state_q <= S_LEVEL;
				S_LEVEL: state_q <= S_MUL;
				S_MUL:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= level_sum[23:16];
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sum_q <= bbg_pkg::NUM_W'(phase_q) + bbg_pkg::NUM_W'(s_tdata);
		end
		if (state_q == S_ANGLE) begin
			angle_q <= angle_prod[ProdW-1:FractionBits];
		end
		if (state_q == S_QUAD) begin
			quad_q  <= quad_c;
			rzero_q <= (r_full == '0);
			if (quad_c[0]) begin
				idx_q <= (r_full == '0) ? '0 : r_mirror[IdxW-1:0];
			end else begin
				idx_q <= r_full[IdxW-1:0];
			end
		end
		if (state_q == S_TABLE) begin
			tbl_q <= sine_rom[idx_q];
		end
		if (state_q == S_LEVEL) begin
			t_q <= smooth_q ? sin_t : lin_t;
		end
		if (state_q == S_MUL) begin
			prod_q <= t_s * level_diff;
		end
	end

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("sequencer took a second tick without going busy");

	a_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_MOD || state_q == S_FRAC))
		else $error("divider finished outside a division state");

	a_phase_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAC && div_rsp.done) |-> (phase_q < period_q))
		else $error("phase not below period after modulo");

	a_result_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (m_tvalid && state_q == S_IDLE))
		else $error("result not presented when leaving the output state");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for breathing_brightness_generator
// Tick transactions go in on the s_* stream. A predictor built from the
// fixed-point breathing algorithm computes each brightness at acceptance. A
// checker compares every m_* result against the oldest prediction. Directed
// corner cases come first, then random ticks under several idle/stall mixes
// with register sets changed only between drained phases.
// ----------------------------------------------------------------------------
module tb;

	localparam int FB    = bbg_pkg::FRACTION_BITS;
	localparam int DEPTH = bbg_pkg::SINE_TABLE_DEPTH;
	localparam int IDX_W = bbg_pkg::CFG_IDX_W;

	// indexes the block has no register for
	localparam logic [IDX_W-1:0] REG_UNUSED = 8'd9;
	localparam logic [IDX_W-1:0] REG_TOP    = 8'hFF;

	localparam logic MODE_TRIANGLE = 1'b0;
	localparam logic MODE_SINE     = 1'b1;

	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [15:0] delta;
		logic        running;
	} tick_t;

	// DUT ports
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [15:0]      cfg_data  = '0;

	breathing_brightness_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [15:0] delta_time
		.s_tuser   (s_tuser),   // [0] running
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] brightness
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state, mirrors the block's registers and phase
	logic [15:0]   quarter_sine [DEPTH];
	logic [31:0]   phase_acc  = '0;
	logic [FB-1:0] progress   = '0;
	logic [15:0]   period_reg = '0;
	logic [7:0]    min_reg    = '0;
	logic [7:0]    max_reg    = '0;
	logic          smooth_reg = MODE_SINE;

	tick_t       tick_fifo    [$];
	logic [7:0]  brightness_q [$];
	tick_t       tick_on_bus;
	int unsigned ticks_sent     = 0;
	int unsigned ticks_accepted = 0;
	int unsigned result_count   = 0;
	int unsigned errors         = 0;
	int          send_idle      = 0;
	int          recv_stall     = 0;
	logic        hold_on        = 1'b0;
	event        hold_go;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("breathing_brightness_generator test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Quarter-wave entry: Q30 Taylor series to degree 13, rounded half up
	function automatic logic [15:0] sine_entry(int unsigned i);
		logic [63:0] x, x2, acc, s, d;
		x   = (64'(i) * bbg_pkg::HALF_PI_Q30) / 64'(DEPTH);
		x2  = (x * x) >> 30;
		acc = bbg_pkg::Q30_ONE;
		for (int k = 0; k < 6; k++) begin
			d   = 64'((12 - 2 * k) * (13 - 2 * k));
			acc = bbg_pkg::Q30_ONE - ((x2 * acc) >> 30) / d;
		end
		s = (x * acc) >> 30;
		s = (s * 64'(bbg_pkg::SINE_FULL) + (64'd1 << 29)) >> 30;
		if (s > 64'd65535)
			s = 64'd65535;
		return s[15:0];
	endfunction

	// Waveform value in Q1.15, range [-1, 1]
	function automatic logic signed [17:0] wave_level();
		logic [63:0] angle;
		int unsigned quad, rem;
		logic [16:0] mag;
		if (smooth_reg == MODE_SINE) begin
			angle = (64'(progress) * 64'(4 * DEPTH)) >> FB;
			quad  = 32'((angle / DEPTH) % 4);
			rem   = 32'(angle % DEPTH);
			if (quad == 0 || quad == 2)
				mag = {1'b0, quarter_sine[rem]};
			else
				mag = (rem == 0) ? bbg_pkg::SINE_FULL : {1'b0, quarter_sine[DEPTH - rem]};
			return (quad >= 2) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
		// triangle over the progress fraction
		if (progress < (1 << (FB - 1)))
			return 18'((64'(progress) << 16) >> FB);
		return 18'(((64'(1) << FB) - 64'(progress)) << 16 >> FB);
	endfunction

	// Advance the phase for a running tick and return the brightness the tick yields
	function automatic logic [7:0] predict_brightness(logic [15:0] delta, logic running);
		longint lvl, sum;
		if (running) begin
			if (period_reg != 0) begin
				phase_acc = (phase_acc + 32'(delta)) % 32'(period_reg);
				progress  = FB'((64'(phase_acc) << FB) / 64'(period_reg));
			end else begin
				phase_acc = '0;
				progress  = '0;
			end
		end
		lvl = longint'(wave_level()) + 32768;
		sum = longint'(min_reg) * 65536 + lvl * (longint'(max_reg) - longint'(min_reg));
		if (sum < 0)
			sum = 0;
		return sum[23:16];
	endfunction

	// ------------------------------------------------------------------------
	// Stream driver, receiver and checker
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		errors++;
		$display("[%0t] mismatch, %s at result %0d: got %0d, expected %0d",
			$time, what, result_count, got, want);
	endtask

	// Tick driver: predicts at acceptance, offers the next queued tick
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			brightness_q.push_back(predict_brightness(s_tdata, s_tuser));
			ticks_accepted++;
		end
		if (!s_tvalid || s_tready) begin
			if (tick_fifo.size() != 0 && $urandom_range(99) >= send_idle) begin
				tick_on_bus = tick_fifo.pop_front();
				s_tdata  <= tick_on_bus.delta;
				s_tuser  <= tick_on_bus.running;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls
	always @(posedge clk) begin
		if (hold_on)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// Long receiver hold-off, counted in cycles
	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (brightness_q.size() == 0)
				report_mismatch("unexpected result", m_tdata, 8'h00);
			else if (m_tdata !== brightness_q[0])
				report_mismatch("brightness", m_tdata, brightness_q[0]);
			if (brightness_q.size() != 0)
				void'(brightness_q.pop_front());
			result_count++;
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus tasks
	// ------------------------------------------------------------------------

	// Queue one tick and return once the driver has put it on the bus
	task automatic send_tick(logic [15:0] delta, logic running);
		tick_fifo.push_back(tick_t'{delta, running});
		ticks_sent++;
		while (tick_fifo.size() != 0)
			@(posedge clk);
	endtask

	// Block until every tick is accepted and every result has come back
	task automatic wait_idle();
		while (ticks_accepted != ticks_sent || brightness_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One register write transaction; caller drops cfg_valid afterwards
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bbg_pkg::REG_PERIOD: period_reg = data;
			bbg_pkg::REG_MIN:    min_reg    = data[7:0];
			bbg_pkg::REG_MAX:    max_reg    = data[7:0];
			bbg_pkg::REG_SMOOTH: smooth_reg = data[0];
			default: ;
		endcase
	endtask

	// Write all registers once the block is idle; unused upper bits random
	task automatic configure(logic [15:0] period, logic [7:0] lo, logic [7:0] hi, logic mode);
		wait_idle();
		write_reg(bbg_pkg::REG_PERIOD, period);
		write_reg(bbg_pkg::REG_MIN, {8'($urandom), lo});
		write_reg(bbg_pkg::REG_MAX, {8'($urandom), hi});
		write_reg(bbg_pkg::REG_SMOOTH, {15'($urandom), mode});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_period();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(2, 16));
			4:       return 16'd1024;
			5, 6:    return 16'($urandom_range(100, 4000));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_level();
		case ($urandom_range(5))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Register reset values: period zero, both levels zero
	task automatic test_reset_defaults();
		send_tick(16'hFFFF, 1'b1);
	endtask

	// Sine quadrant boundaries, full-scale delta, held tick
	task automatic test_sine_extremes();
		configure(16'd1024, 8'd0, 8'd255, MODE_SINE);
		send_tick(16'd0, 1'b1);
		for (int n = 0; n < 4; n++)
			send_tick(16'd256, 1'b1);
		send_tick(16'd0, 1'b0);
		send_tick(16'hFFFF, 1'b1);
		send_tick(16'd1, 1'b1);
	endtask

	// Triangle around the half-period point
	task automatic test_triangle();
		configure(16'd1024, 8'd0, 8'd255, MODE_TRIANGLE);
		send_tick(16'd511, 1'b1);
		send_tick(16'd1, 1'b1);
		send_tick(16'd1, 1'b1);
		send_tick(16'd511, 1'b1);
		send_tick(16'd0, 1'b0);
	endtask

	// Max below min, and min equal to max
	task automatic test_level_order();
		configure(16'd1000, 8'd255, 8'd0, MODE_SINE);
		send_tick(16'd250, 1'b1);
		send_tick(16'd500, 1'b1);
		configure(16'd1000, 8'd77, 8'd77, MODE_TRIANGLE);
		send_tick(16'd123, 1'b1);
	endtask

	// Zero period clears phase; period of one
	task automatic test_zero_period();
		configure(16'd0, 8'd10, 8'd200, MODE_SINE);
		send_tick(16'd500, 1'b1);
		send_tick(16'd500, 1'b0);
		configure(16'd1, 8'd10, 8'd200, MODE_SINE);
		send_tick(16'hFFFF, 1'b1);
	endtask

	// Held phase above a new, shorter period
	task automatic test_period_change();
		configure(16'd60000, 8'd0, 8'd255, MODE_SINE);
		send_tick(16'd50000, 1'b1);
		configure(16'd100, 8'd0, 8'd255, MODE_SINE);
		send_tick(16'd0, 1'b0);
		send_tick(16'd7, 1'b1);
	endtask

	// Writes to indexes with no register are dropped
	task automatic test_unknown_index();
		wait_idle();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_TOP, 16'h5A5A);
		write_reg(bbg_pkg::REG_MIN, 16'hAB05);
		cfg_valid <= 1'b0;
		send_tick(16'd0, 1'b0);
	endtask

	// Random ticks, register set changed every few dozen ticks
	task automatic test_random(int idle_pct, int stall_pct, int count);
		int unsigned left_in_set;
		logic [15:0] delta;
		send_idle   = idle_pct;
		recv_stall  = stall_pct;
		left_in_set = 0;
		for (int n = 0; n < count; n++) begin
			if (left_in_set == 0) begin
				configure(rand_period(), rand_level(), rand_level(), 1'($urandom));
				left_in_set = $urandom_range(40, 120);
			end
			left_in_set--;
			case ($urandom_range(3))
				0:       delta = 16'($urandom);
				1:       delta = 16'($urandom_range(0, 40));
				default: delta = (period_reg == 0) ? 16'($urandom)
				                                   : 16'($urandom_range(0, period_reg));
			endcase
			send_tick(delta, $urandom_range(99) < 85);
		end
	endtask

	// Receiver holds off while ticks keep coming, then sender pauses to drain
	task automatic test_backpressure();
		send_idle  = 0;
		recv_stall = 0;
		configure(16'd500, 8'd20, 8'd230, MODE_SINE);
		-> hold_go;
		for (int n = 0; n < 12; n++)
			send_tick(16'($urandom_range(0, 600)), 1'b1);
		wait_idle();
		for (int n = 0; n < 10; n++)
			send_tick(16'($urandom), 1'($urandom));
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			quarter_sine[i] = sine_entry(i);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_sine_extremes();
		test_triangle();
		test_level_order();
		test_zero_period();
		test_period_change();
		test_unknown_index();
		test_random(0, 0, 370);
		test_random(75, 0, 370);
		test_random(0, 75, 370);
		test_random(37, 37, 370);
		test_backpressure();

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0 && brightness_q.size() == 0)
			$display("breathing_brightness_generator test passed");
		else
			$display("breathing_brightness_generator test failed");
		$finish;
	end

endmodule
